// ===== hw/rtl/fqnt4_pkg.sv =====
// fqnt4_pkg: shared types, character codes and base encoding for the
// FASTQ record parser. No dependencies.
`default_nettype none

package fqnt4_pkg;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SEEK  = 7'b0000001,
    PH_NAME  = 7'b0000010,
    PH_HDR   = 7'b0000100,
    PH_SEQ   = 7'b0001000,
    PH_PLUS  = 7'b0010000,
    PH_QUAL  = 7'b0100000,
    PH_START = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_SEQ  = 2'd1,
    KIND_QUAL = 2'd2
  } kind_t;

  localparam int unsigned CNT_W = 24;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_UT    = 8'h54;
  localparam logic [7:0] CH_LT    = 8'h74;

  localparam logic [7:0] CODE_A   = 8'd0;
  localparam logic [7:0] CODE_C   = 8'd1;
  localparam logic [7:0] CODE_G   = 8'd2;
  localparam logic [7:0] CODE_T   = 8'd3;
  localparam logic [7:0] CODE_N   = 8'd4;
  localparam logic [7:0] CODE_GAP = 8'd5;

  function automatic logic [7:0] base_code(input logic [7:0] b);
    logic [7:0] code;
    case (b) inside
      CH_UA, CH_LA: code = CODE_A;
      CH_UC, CH_LC: code = CODE_C;
      CH_UG, CH_LG: code = CODE_G;
      CH_UT, CH_LT: code = CODE_T;
      CH_DASH:      code = CODE_GAP;
      default:      code = CODE_N;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fastq_parse_nt4_encode_core.sv =====
// fastq_parse_nt4_encode_core: byte-serial FASTQ record parser that emits
// name and quality bytes and nt4-coded sequence bytes with record tags.
// Depends on fqnt4_pkg.
//
// Usage:
//   in channel  : one chunk byte per transfer (in_byte), in_chunk_last on the
//                 final byte of a chunk.
//   out channel : at most one result per input byte. A payload byte is held
//                 internally until the following byte arrives (field_end looks
//                 one byte ahead), so a payload byte is reported with the
//                 transfer of the byte after it. The last byte of a chunk
//                 always yields a result carrying chunk_done and the count.
//   latency     : the result for an input byte is on the out port the cycle
//                 after its transfer.
//   throughput  : one byte per cycle while the output is not stalled; the parse step is a single pass of
//                 logic between the phase/counter registers and the output
//                 register.
//   stall       : while out_valid is high and out_ready is low, in_ready is
//                 low; the output register holds its result.
//   reset       : rst_n low clears the phase to seek-'@', all counters and the
//                 held byte; the same happens after each chunk's last byte.
`default_nettype none

module fastq_parse_nt4_encode_core #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   in_byte,
  input  wire                          in_chunk_last,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_payload_valid,
  output logic [1:0]                   out_field_kind,
  output logic [7:0]                   out_value,
  output logic                         out_field_end,
  output logic [fqnt4_pkg::CNT_W-1:0]  out_record_index,
  output logic [fqnt4_pkg::CNT_W-1:0]  out_field_offset,
  output logic                         out_chunk_done,
  output logic [fqnt4_pkg::CNT_W-1:0]  out_record_count
);
  import fqnt4_pkg::*;

  // held offset keeps only the bits that reach the output
  localparam int unsigned HOFF_W = (OFFSET_BITS < CNT_W) ? OFFSET_BITS : CNT_W;

  // state
  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       rec_cnt_r, rec_cnt_nxt;
  logic [OFFSET_BITS-1:0] name_pos_r, name_pos_nxt;
  logic [OFFSET_BITS-1:0] seq_pos_r, seq_pos_nxt;
  logic [OFFSET_BITS-1:0] qual_pos_r, qual_pos_nxt;

  logic                   held_vld_r, held_vld_nxt;
  kind_t                  held_kind_r, held_kind_nxt;
  logic [7:0]             held_val_r, held_val_nxt;
  logic [CNT_W-1:0]       held_rec_r, held_rec_nxt;
  logic [HOFF_W-1:0]      held_off_r, held_off_nxt;

  // output register
  logic                   out_vld_r, out_vld_nxt;
  logic                   o_pay_r, o_pay_nxt;
  logic [1:0]             o_kind_r, o_kind_nxt;
  logic [7:0]             o_val_r, o_val_nxt;
  logic                   o_end_r, o_end_nxt;
  logic [CNT_W-1:0]       o_rec_r, o_rec_nxt;
  logic [CNT_W-1:0]       o_off_r, o_off_nxt;
  logic                   o_done_r, o_done_nxt;
  logic [CNT_W-1:0]       o_cnt_r, o_cnt_nxt;

  // step decode
  logic                   acc;
  logic                   pay;
  kind_t                  kind;
  logic [7:0]             val;
  phase_t                 nxt_ph;
  logic                   begin_rec;
  logic [CNT_W-1:0]       rec_upd;
  logic [OFFSET_BITS-1:0] cur_pos;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   emit;

  assign in_ready = !out_vld_r || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    pay       = 1'b0;
    kind      = KIND_NAME;
    val       = in_byte;
    nxt_ph    = phase_r;
    begin_rec = 1'b0;
    case (phase_r)
      PH_NAME: begin
        if (in_byte == CH_SP) begin
          nxt_ph = PH_HDR;
        end else if (in_byte == CH_NL) begin
          nxt_ph = PH_SEQ;
        end else begin
          pay = 1'b1;
        end
      end
      PH_HDR: begin
        if (in_byte == CH_NL) nxt_ph = PH_SEQ;
      end
      PH_SEQ: begin
        if (in_byte == CH_NL) begin
          nxt_ph = PH_PLUS;
        end else begin
          pay  = 1'b1;
          kind = KIND_SEQ;
          val  = base_code(in_byte);
        end
      end
      PH_PLUS: begin
        if (in_byte == CH_NL) nxt_ph = PH_QUAL;
      end
      PH_QUAL: begin
        if (in_byte == CH_NL) begin
          nxt_ph = PH_START;
        end else begin
          pay  = 1'b1;
          kind = KIND_QUAL;
        end
      end
      PH_START: begin
        // any byte opens the next record
        begin_rec = 1'b1;
        nxt_ph    = PH_NAME;
      end
      default: begin
        if (in_byte == CH_AT) begin
          begin_rec = 1'b1;
          nxt_ph    = PH_NAME;
        end else begin
          nxt_ph = PH_SEEK;
        end
      end
    endcase
  end

  assign rec_upd = (begin_rec && (rec_cnt_r != {CNT_W{1'b1}})) ?
                   rec_cnt_r + 1'b1 : rec_cnt_r;

  always_comb begin
    case (kind)
      KIND_NAME: cur_pos = name_pos_r;
      KIND_SEQ:  cur_pos = seq_pos_r;
      default:   cur_pos = qual_pos_r;
    endcase
  end

  assign pos_inc = (cur_pos == {OFFSET_BITS{1'b1}}) ? cur_pos : cur_pos + 1'b1;
  assign emit    = held_vld_r || in_chunk_last;

  // state update
  always_comb begin
    phase_nxt     = phase_r;
    rec_cnt_nxt   = rec_cnt_r;
    name_pos_nxt  = name_pos_r;
    seq_pos_nxt   = seq_pos_r;
    qual_pos_nxt  = qual_pos_r;
    held_vld_nxt  = held_vld_r;
    held_kind_nxt = held_kind_r;
    held_val_nxt  = held_val_r;
    held_rec_nxt  = held_rec_r;
    held_off_nxt  = held_off_r;
    if (acc) begin
      if (in_chunk_last) begin
        phase_nxt    = PH_SEEK;
        rec_cnt_nxt  = '0;
        name_pos_nxt = '0;
        seq_pos_nxt  = '0;
        qual_pos_nxt = '0;
        held_vld_nxt = 1'b0;
      end else begin
        phase_nxt    = nxt_ph;
        rec_cnt_nxt  = rec_upd;
        held_vld_nxt = pay;
        if (pay) begin
          held_kind_nxt = kind;
          held_val_nxt  = val;
          held_rec_nxt  = (rec_upd == '0) ? '0 : rec_upd - 1'b1;
          held_off_nxt  = cur_pos[HOFF_W-1:0];
          case (kind)
            KIND_NAME: name_pos_nxt = pos_inc;
            KIND_SEQ:  seq_pos_nxt  = pos_inc;
            default:   qual_pos_nxt = pos_inc;
          endcase
        end
      end
    end
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    o_pay_nxt   = o_pay_r;
    o_kind_nxt  = o_kind_r;
    o_val_nxt   = o_val_r;
    o_end_nxt   = o_end_r;
    o_rec_nxt   = o_rec_r;
    o_off_nxt   = o_off_r;
    o_done_nxt  = o_done_r;
    o_cnt_nxt   = o_cnt_r;
    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;
    if (acc && emit) begin
      out_vld_nxt = 1'b1;
      o_pay_nxt   = held_vld_r;
      o_kind_nxt  = held_vld_r ? held_kind_r : KIND_NAME;
      o_val_nxt   = held_vld_r ? held_val_r : '0;
      o_end_nxt   = held_vld_r && (!pay || in_chunk_last);
      o_rec_nxt   = held_vld_r ? held_rec_r : '0;
      o_off_nxt   = held_vld_r ? CNT_W'(held_off_r) : '0;
      o_done_nxt  = in_chunk_last;
      o_cnt_nxt   = rec_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEEK;
      rec_cnt_r  <= '0;
      name_pos_r <= '0;
      seq_pos_r  <= '0;
      qual_pos_r <= '0;
      held_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
      name_pos_r <= name_pos_nxt;
      seq_pos_r  <= seq_pos_nxt;
      qual_pos_r <= qual_pos_nxt;
      held_vld_r <= held_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_kind_r <= held_kind_nxt;
    held_val_r  <= held_val_nxt;
    held_rec_r  <= held_rec_nxt;
    held_off_r  <= held_off_nxt;
    o_pay_r     <= o_pay_nxt;
    o_kind_r    <= o_kind_nxt;
    o_val_r     <= o_val_nxt;
    o_end_r     <= o_end_nxt;
    o_rec_r     <= o_rec_nxt;
    o_off_r     <= o_off_nxt;
    o_done_r    <= o_done_nxt;
    o_cnt_r     <= o_cnt_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_payload_valid = o_pay_r;
  assign out_field_kind    = o_kind_r;
  assign out_value         = o_val_r;
  assign out_field_end     = o_end_r;
  assign out_record_index  = o_rec_r;
  assign out_field_offset  = o_off_r;
  assign out_chunk_done    = o_done_r;
  assign out_record_count  = o_cnt_r;

`ifndef NO_ASSERTIONS
  // a chunk's last byte always clears the parser
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_chunk_last |=> !held_vld_r && (rec_cnt_r == '0) && (phase_r == PH_SEEK))
    else $error("state not cleared after chunk end");

  // a held payload byte only exists inside a record body
  a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
    held_vld_r |-> (phase_r != PH_SEEK) && (phase_r != PH_START))
    else $error("payload held outside a record");

  // record count never drops within a chunk
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_chunk_last |=> rec_cnt_r >= $past(rec_cnt_r))
    else $error("record counter went backwards");

  // a byte that needs a result is only taken when the result can be stored
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |-> !acc)
    else $error("input taken while output stalled");

  // results without payload carry zero tags
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !o_pay_r |-> o_done_r && !o_end_r && (o_off_r == '0) && (o_rec_r == '0))
    else $error("empty result with stray fields");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for fastq_parse_nt4_encode_core, byte stream in, tagged results out.
// Depends on fqnt4_pkg and the core; a local parser model predicts every result transfer.
`default_nettype none

module tb_top;
  import fqnt4_pkg::*;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          IDLE_PCT = 23;
  localparam logic [7:0]  CH_PLUS = 8'h2B;
  localparam logic [7:0]  CH_UN = 8'h4E;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } chunk_byte_t;

  typedef struct {
    logic             pay;
    kind_t            kind;
    logic [7:0]       value;
    logic             fend;
    logic [CNT_W-1:0] rec;
    logic [CNT_W-1:0] off;
    logic             done;
    logic [CNT_W-1:0] count;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_byte = '0;
  logic             in_chunk_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_payload_valid;
  logic [1:0]       out_field_kind;
  logic [7:0]       out_value;
  logic             out_field_end;
  logic [CNT_W-1:0] out_record_index;
  logic [CNT_W-1:0] out_field_offset;
  logic             out_chunk_done;
  logic [CNT_W-1:0] out_record_count;

  fastq_parse_nt4_encode_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_chunk_last    (in_chunk_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_valid(out_payload_valid),
    .out_field_kind   (out_field_kind),
    .out_value        (out_value),
    .out_field_end    (out_field_end),
    .out_record_index (out_record_index),
    .out_field_offset (out_field_offset),
    .out_chunk_done   (out_chunk_done),
    .out_record_count (out_record_count)
  );

  chunk_byte_t   pending_bytes[$];
  parse_result_t expected_results[$];
  logic [7:0]    chunk_buf[$];

  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int cycles = 0;
  logic calm;

  // no idling on either side through this window of transfers
  assign calm = (accepted >= 600) && (accepted < 900);

  // parser model state
  phase_t                 phase;
  logic [CNT_W-1:0]       rec_cnt;
  logic [OFFSET_BITS-1:0] name_pos;
  logic [OFFSET_BITS-1:0] seq_pos;
  logic [OFFSET_BITS-1:0] qual_pos;
  parse_result_t          held;

  task automatic log_error(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) begin
      log_error($sformatf("result %0d %s got 0x%0h want 0x%0h", results_seen, name, got, want));
    end
  endtask

  function automatic logic [CNT_W-1:0] sat_next(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [7:0] nt4_of(input logic [7:0] b);
    logic [7:0] code;
    case (b)
      CH_UA, CH_LA: code = CODE_A;
      CH_UC, CH_LC: code = CODE_C;
      CH_UG, CH_LG: code = CODE_G;
      CH_UT, CH_LT: code = CODE_T;
      CH_DASH:      code = CODE_GAP;
      default:      code = CODE_N;
    endcase
    return code;
  endfunction

  task automatic clear_parser();
    phase = PH_SEEK;
    rec_cnt = '0;
    name_pos = '0;
    seq_pos = '0;
    qual_pos = '0;
    held.pay = 1'b0;
    held.kind = KIND_NAME;
    held.value = '0;
    held.fend = 1'b0;
    held.rec = '0;
    held.off = '0;
    held.done = 1'b0;
    held.count = '0;
  endtask

  // one accepted byte: advance the model and queue the result it causes
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic          pay;
    kind_t         kind;
    logic [7:0]    val;
    phase_t        nxt;
    logic          start;
    parse_result_t r;
    pay = 1'b0;
    kind = KIND_NAME;
    val = '0;
    nxt = phase;
    start = 1'b0;
    case (phase)
      PH_NAME: begin
        if (b == CH_SP) nxt = PH_HDR;
        else if (b == CH_NL) nxt = PH_SEQ;
        else begin
          pay = 1'b1;
          kind = KIND_NAME;
          val = b;
        end
      end
      PH_HDR: begin
        if (b == CH_NL) nxt = PH_SEQ;
      end
      PH_SEQ: begin
        if (b == CH_NL) nxt = PH_PLUS;
        else begin
          pay = 1'b1;
          kind = KIND_SEQ;
          val = nt4_of(b);
        end
      end
      PH_PLUS: begin
        if (b == CH_NL) nxt = PH_QUAL;
      end
      PH_QUAL: begin
        if (b == CH_NL) nxt = PH_START;
        else begin
          pay = 1'b1;
          kind = KIND_QUAL;
          val = b;
        end
      end
      PH_START: begin
        // any byte opens the next record
        start = 1'b1;
        nxt = PH_NAME;
      end
      default: begin
        if (b == CH_AT) begin
          start = 1'b1;
          nxt = PH_NAME;
        end else begin
          nxt = PH_SEEK;
        end
      end
    endcase
    if (start) rec_cnt = sat_next(rec_cnt);
    if (held.pay || last) begin
      r = held;
      r.fend = held.pay && (!pay || last);
      r.done = last;
      r.count = rec_cnt;
      expected_results.push_back(r);
    end
    if (last) begin
      clear_parser();
    end else begin
      held.pay = pay;
      held.kind = kind;
      held.value = val;
      held.rec = pay ? ((rec_cnt == '0) ? '0 : rec_cnt - 1'b1) : '0;
      held.off = '0;
      if (pay) begin
        case (kind)
          KIND_NAME: begin
            held.off = name_pos;
            name_pos = sat_next(name_pos);
          end
          KIND_SEQ: begin
            held.off = seq_pos;
            seq_pos = sat_next(seq_pos);
          end
          default: begin
            held.off = qual_pos;
            qual_pos = sat_next(qual_pos);
          end
        endcase
      end
      phase = nxt;
    end
  endtask

  // stimulus helpers
  task automatic push_item(input logic [7:0] b, input logic last);
    chunk_byte_t item;
    item.b = b;
    item.last = last;
    pending_bytes.push_back(item);
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_item(s[i], last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] ex1, input logic [7:0] ex2);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == ex1 || v == ex2) v = 8'($urandom);
    return v;
  endfunction

  function automatic logic [7:0] seq_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) return pick_byte(CH_NL, CH_NL);
    case ($urandom_range(0, 9))
      0: c = CH_UA;
      1: c = CH_LA;
      2: c = CH_UC;
      3: c = CH_LC;
      4: c = CH_UG;
      5: c = CH_LG;
      6: c = CH_UT;
      7: c = CH_LT;
      8: c = CH_DASH;
      default: c = CH_UN;
    endcase
    return c;
  endfunction

  task automatic add_record(input logic with_at);
    chunk_buf.push_back(with_at ? CH_AT : 8'($urandom));
    repeat ($urandom_range(0, 8)) chunk_buf.push_back(pick_byte(CH_SP, CH_NL));
    if ($urandom_range(0, 1) == 1) begin
      chunk_buf.push_back(CH_SP);
      repeat ($urandom_range(0, 5)) chunk_buf.push_back(pick_byte(CH_NL, CH_NL));
    end
    chunk_buf.push_back(CH_NL);
    repeat ($urandom_range(0, 12)) chunk_buf.push_back(seq_char());
    chunk_buf.push_back(CH_NL);
    chunk_buf.push_back(CH_PLUS);
    repeat ($urandom_range(0, 2)) chunk_buf.push_back(pick_byte(CH_NL, CH_NL));
    chunk_buf.push_back(CH_NL);
    repeat ($urandom_range(0, 12)) chunk_buf.push_back(pick_byte(CH_NL, CH_NL));
    chunk_buf.push_back(CH_NL);
  endtask

  task automatic add_chunk();
    int nrec;
    int cut;
    chunk_buf.delete();
    if ($urandom_range(0, 7) == 0) begin
      // noise chunk with scattered '@'
      repeat ($urandom_range(1, 20)) begin
        chunk_buf.push_back(($urandom_range(0, 3) == 0) ? CH_AT : 8'($urandom));
      end
    end else begin
      repeat ($urandom_range(0, 3)) chunk_buf.push_back(pick_byte(CH_AT, CH_AT));
      nrec = $urandom_range(1, 4);
      for (int i = 0; i < nrec; i++) add_record((i == 0) || ($urandom_range(0, 3) != 0));
      if ($urandom_range(0, 3) == 0) chunk_buf.push_back(8'($urandom));
    end
    // some chunks end in the middle of a record
    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, chunk_buf.size()) : chunk_buf.size();
    for (int i = 0; i < cut; i++) push_item(chunk_buf[i], i == cut - 1);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    clear_parser();
    // junk before the first '@', byte extremes, every base code
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_text("@n", 1'b0);
    push_item(8'hFF, 1'b0);
    push_text(" x\naCgT-", 1'b0);
    push_item(8'hFF, 1'b0);
    // non-'@' record start, name closed by newline, empty plus line,
    // payload byte on the chunk's last byte
    push_text("\n+\n!\nXq\nA\n\n!~", 1'b1);
    // chunk that ends while still seeking
    push_text("Q", 1'b1);
    // held name byte closed by a non-payload last byte
    push_text("@a\n", 1'b1);
    while (pending_bytes.size() < RANDOM_ITEMS + 30) add_chunk();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      log_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // driver: valid is held with its byte until the transfer
  always @(posedge clk) begin : driver
    chunk_byte_t item;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte, in_chunk_last);
        accepted++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte <= item.b;
          in_chunk_last <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result transfer is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    parse_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        log_error("result with nothing expected");
      end else begin
        e = expected_results.pop_front();
        check_field("payload_valid", CNT_W'(out_payload_valid), CNT_W'(e.pay));
        check_field("field_kind", CNT_W'(out_field_kind), CNT_W'(e.kind));
        check_field("value", CNT_W'(out_value), CNT_W'(e.value));
        check_field("field_end", CNT_W'(out_field_end), CNT_W'(e.fend));
        check_field("record_index", out_record_index, e.rec);
        check_field("field_offset", out_field_offset, e.off);
        check_field("chunk_done", CNT_W'(out_chunk_done), CNT_W'(e.done));
        check_field("record_count", out_record_count, e.count);
      end
      results_seen++;
    end
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      log_error("timeout");
      $display("tb: failure");
      $finish;
    end
  end

endmodule

`default_nettype wire
